/* hw/rtl/sme_pkg.sv */
// Shared types and codes for the stack machine executor.
package sme_pkg;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_POP   = 4'd1,
    OP_DUP   = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_MULT  = 4'd5,
    OP_DIV   = 4'd6,
    OP_MOD   = 4'd7,
    OP_PRINT = 4'd8
  } opcode_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_BADOP   = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_SHIFT_IN  = 2'd1,  // take the word from the neighbor above
    CELL_SHIFT_OUT = 2'd2   // take the word from the neighbor below
  } cell_op_t;

  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1,
    MD_MOD = 2'd2
  } md_kind_t;

  typedef struct packed {
    logic     start;
    md_kind_t kind;
  } md_req_t;

endpackage

/* hw/rtl/sme_cell.sv */
// One stack entry: holds a word or takes it from a neighbor.
module sme_cell #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                   clk,
  input  sme_pkg::cell_op_t      op,
  input  logic [WORD_WIDTH-1:0]  d_above,
  input  logic [WORD_WIDTH-1:0]  d_below,
  output logic [WORD_WIDTH-1:0]  q
);

  logic [WORD_WIDTH-1:0] word_r;

  always_ff @(posedge clk) begin
    unique case (op)
      sme_pkg::CELL_SHIFT_IN:  word_r <= d_above;
      sme_pkg::CELL_SHIFT_OUT: word_r <= d_below;
      default:                 word_r <= word_r;
    endcase
  end

  assign q = word_r;

endmodule

/* hw/rtl/sme_muldiv.sv */
// Bit-serial multiplier and signed divider, one bit per cycle.
module sme_muldiv #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sme_pkg::md_req_t       req,
  input  logic [WORD_WIDTH-1:0]  a,
  input  logic [WORD_WIDTH-1:0]  b,
  output logic                   done,
  output logic [WORD_WIDTH-1:0]  result
);

  localparam int SW = $clog2(WORD_WIDTH);

  typedef enum logic [1:0] {MD_IDLE, MD_RUN, MD_DONE} md_state_t;

  md_state_t             state_r;
  sme_pkg::md_kind_t     kind_r;
  logic [SW-1:0]         step_r;
  logic [WORD_WIDTH-1:0] acc_r;   // product or partial remainder
  logic [WORD_WIDTH-1:0] x_r;     // multiplicand or dividend/quotient
  logic [WORD_WIDTH-1:0] y_r;     // multiplier or divisor magnitude
  logic                  neg_q_r;
  logic                  neg_r_r;

  logic                  a_neg;
  logic                  b_neg;
  logic [WORD_WIDTH-1:0] a_mag;
  logic [WORD_WIDTH-1:0] b_mag;
  logic [WORD_WIDTH:0]   shifted;
  logic [WORD_WIDTH:0]   diff;
  logic [WORD_WIDTH-1:0] rem;

  assign a_neg   = a[WORD_WIDTH-1];
  assign b_neg   = b[WORD_WIDTH-1];
  assign a_mag   = a_neg ? (~a + 1'b1) : a;
  assign b_mag   = b_neg ? (~b + 1'b1) : b;
  assign shifted = {acc_r, x_r[WORD_WIDTH-1]};
  assign diff    = shifted - {1'b0, y_r};
  assign rem     = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      unique case (state_r)
        MD_IDLE: begin
          if (req.start) begin
            state_r <= MD_RUN;
            kind_r  <= req.kind;
            step_r  <= SW'(WORD_WIDTH - 1);
            acc_r   <= '0;
            neg_q_r <= a_neg ^ b_neg;
            neg_r_r <= a_neg;
            if (req.kind == sme_pkg::MD_MUL) begin
              x_r <= a;
              y_r <= b;
            end else begin
              x_r <= a_mag;
              y_r <= b_mag;
            end
          end
        end
        MD_RUN: begin
          if (kind_r == sme_pkg::MD_MUL) begin
            if (y_r[0]) acc_r <= acc_r + x_r;
            x_r <= {x_r[WORD_WIDTH-2:0], 1'b0};
            y_r <= {1'b0, y_r[WORD_WIDTH-1:1]};
          end else if (!diff[WORD_WIDTH]) begin
            acc_r <= diff[WORD_WIDTH-1:0];
            x_r   <= {x_r[WORD_WIDTH-2:0], 1'b1};
          end else begin
            // partial remainder stays below the divisor, so the top bit is zero
            acc_r <= shifted[WORD_WIDTH-1:0];
            x_r   <= {x_r[WORD_WIDTH-2:0], 1'b0};
          end
          step_r <= step_r - 1'b1;
          if (step_r == '0) state_r <= MD_DONE;
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

  assign done = (state_r == MD_DONE);

  always_comb begin
    unique case (kind_r)
      sme_pkg::MD_MUL: result = rem;
      sme_pkg::MD_DIV: result = neg_q_r ? (~x_r + 1'b1) : x_r;
      sme_pkg::MD_MOD: result = neg_r_r ? (~rem + 1'b1) : rem;
      default:         result = rem;
    endcase
  end

endmodule

/* hw/rtl/stack_machine_executor.sv */
// Stack machine executor top: instruction sequencer over a chain of stack cells.
//
// Command channel: present in_opcode/in_immediate with start; the word is taken
// at a clock edge where start is high and busy is low. The block latches it.
// Result channel: out_valid is high for exactly one cycle per instruction, with
// out_status, out_top_value, out_print_valid and out_depth. The receiver cannot
// stall, so a result is simply sampled in that cycle.
// Push, pop, dup, add, sub, print and faulted instructions go from S_EXEC
// straight to S_REPORT, where their result is shown. busy is low while the
// result is shown, so a new instruction can be taken then.
// mult, div and mod run on a shared bit-serial unit, one bit per cycle, with
// the sequencer in S_MULDIV; a zero divisor is flagged without starting the unit.
// The stack is a row of STACK_DEPTH cells, top in cell 0; push and pop shift the
// whole row by one entry at once.
// Reset (rst_n low, synchronous) empties the stack and idles the sequencer;
// the cell contents are not cleared, since only entries below the depth are read.
module stack_machine_executor #(
  parameter int STACK_DEPTH = 128,
  parameter int WORD_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_opcode,
  input  logic [30:0]        in_immediate,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_top_value,
  output logic               out_print_valid,
  output logic [7:0]         out_depth
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MULDIV, S_REPORT} state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [2:0]            status_r, status_nxt;
  logic                  print_r, print_nxt;
  logic [3:0]            op_r;
  logic [WORD_WIDTH-1:0] imm_r;

  sme_pkg::cell_op_t     op_top, op_rest;
  logic [WORD_WIDTH-1:0] ext_word;
  logic [WORD_WIDTH-1:0] cell_q [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] top_w, next_w;

  sme_pkg::md_req_t      md_req;
  logic                  md_done;
  logic [WORD_WIDTH-1:0] md_result;
  logic                  accept;

  assign accept = start && !busy;
  assign top_w  = cell_q[0];
  assign next_w = cell_q[1];

  // ---------------- cell row ----------------
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] d_above;
    logic [WORD_WIDTH-1:0] d_below;
    if (i == 0) begin : g_head
      assign d_above = ext_word;
    end else begin : g_body
      assign d_above = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign d_below = '0;
    end else begin : g_inner
      assign d_below = cell_q[i+1];
    end
    sme_cell #(.WORD_WIDTH(WORD_WIDTH)) u_cell (
      .clk     (clk),
      .op      ((i == 0) ? op_top : op_rest),
      .d_above (d_above),
      .d_below (d_below),
      .q       (cell_q[i])
    );
  end

  sme_muldiv #(.WORD_WIDTH(WORD_WIDTH)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .a      (top_w),
    .b      (next_w),
    .done   (md_done),
    .result (md_result)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    print_nxt  = print_r;
    op_top     = sme_pkg::CELL_HOLD;
    op_rest    = sme_pkg::CELL_HOLD;
    ext_word   = imm_r;
    md_req     = '{start: 1'b0, kind: sme_pkg::MD_MUL};

    unique case (state_r)
      S_EXEC: begin
        state_nxt  = S_REPORT;
        status_nxt = sme_pkg::ST_OK;
        print_nxt  = 1'b0;
        unique case (op_r)
          sme_pkg::OP_PUSH: begin
            if (cnt_r == CW'(STACK_DEPTH)) begin
              status_nxt = sme_pkg::ST_OVER;
            end else begin
              op_top  = sme_pkg::CELL_SHIFT_IN;
              op_rest = sme_pkg::CELL_SHIFT_IN;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          sme_pkg::OP_POP: begin
            if (cnt_r == '0) begin
              status_nxt = sme_pkg::ST_UNDER;
            end else begin
              op_top  = sme_pkg::CELL_SHIFT_OUT;
              op_rest = sme_pkg::CELL_SHIFT_OUT;
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          sme_pkg::OP_DUP: begin
            ext_word = top_w;
            if (cnt_r == '0) begin
              status_nxt = sme_pkg::ST_UNDER;
            end else if (cnt_r == CW'(STACK_DEPTH)) begin
              status_nxt = sme_pkg::ST_OVER;
            end else begin
              op_top  = sme_pkg::CELL_SHIFT_IN;
              op_rest = sme_pkg::CELL_SHIFT_IN;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          sme_pkg::OP_ADD, sme_pkg::OP_SUB: begin
            ext_word = (op_r == sme_pkg::OP_ADD) ? (top_w + next_w) : (top_w - next_w);
            if (cnt_r < CW'(2)) begin
              status_nxt = sme_pkg::ST_UNDER;
            end else begin
              op_top  = sme_pkg::CELL_SHIFT_IN;
              op_rest = sme_pkg::CELL_SHIFT_OUT;
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          sme_pkg::OP_MULT, sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
            if (cnt_r < CW'(2)) begin
              status_nxt = sme_pkg::ST_UNDER;
            end else if (op_r != sme_pkg::OP_MULT && next_w == '0) begin
              status_nxt = sme_pkg::ST_DIVZERO;
            end else begin
              md_req.start = 1'b1;
              md_req.kind  = (op_r == sme_pkg::OP_MULT) ? sme_pkg::MD_MUL :
                             (op_r == sme_pkg::OP_DIV)  ? sme_pkg::MD_DIV : sme_pkg::MD_MOD;
              state_nxt    = S_MULDIV;
            end
          end
          sme_pkg::OP_PRINT: begin
            if (cnt_r == '0) status_nxt = sme_pkg::ST_UNDER;
            else             print_nxt  = 1'b1;
          end
          default: status_nxt = sme_pkg::ST_BADOP;
        endcase
      end
      S_MULDIV: begin
        ext_word = md_result;
        if (md_done) begin
          op_top    = sme_pkg::CELL_SHIFT_IN;
          op_rest   = sme_pkg::CELL_SHIFT_OUT;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_REPORT;
        end
      end
      S_IDLE, S_REPORT: begin
        state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      status_r <= sme_pkg::ST_OK;
      print_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
      print_r  <= print_nxt;
    end
  end

  // latched instruction word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      imm_r <= WORD_WIDTH'(in_immediate);
    end
  end

  assign busy            = (state_r == S_EXEC) || (state_r == S_MULDIV);
  assign out_valid       = (state_r == S_REPORT);
  assign out_status      = status_r;
  assign out_print_valid = out_valid && print_r;
  assign out_depth       = 8'(cnt_r);
  assign out_top_value   = (cnt_r == '0) ? 32'sd0 : 32'($signed(top_w));

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid)
    else $error("accepted instruction did not start execution");

  a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_print_valid |-> out_status == sme_pkg::ST_OK && cnt_r != '0)
    else $error("print flagged without a value");

  a_md_done: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == S_MULDIV)
    else $error("arithmetic unit finished outside its wait state");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> cnt_r == $past(cnt_r))
    else $error("stack count moved while idle");
`endif

endmodule
